// ----- src/rqle_pkg.sv -----
// types, codes and helpers shared by the register query link engine
`default_nettype none

package rqle_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic CFG_PROTOCOL = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [7:0] S_HEAD   = 8'h02;
    localparam logic [7:0] I_HEAD   = 8'h03;
    localparam logic [7:0] I_CMD    = 8'h40;
    localparam logic [7:0] REJ_B0   = 8'h15;
    localparam logic [7:0] REJ_B1   = 8'hEA;
    localparam logic [7:0] ID_SHORT = 8'h50;
    localparam logic [7:0] ID_TINY  = 8'h56;

    localparam logic [8:0] LEN_SHORT   = 9'd6;
    localparam logic [8:0] LEN_TINY    = 9'd4;
    localparam logic [8:0] LEN_S_OTHER = 9'd18;
    localparam logic [8:0] LEN_I_START = 9'd12;
    localparam logic [8:0] LEN_I_POS   = 9'd3;
    localparam logic [8:0] LEN_I_EXTRA = 9'd2;
    localparam logic [8:0] REJ_POS     = 9'd2;

    localparam logic [2:0] S_FRAME_LEN = 3'd3;
    localparam logic [2:0] I_FRAME_LEN = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] register_id;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
        logic [6:0] reply_count;
    } resp_t;

    typedef struct packed {
        logic [2:0]      count;
        resp_t [3:0]     items;
    } batch_t;

    typedef struct packed {
        logic busy;
    } core_status_t;

    function automatic resp_t make_resp(logic [1:0] kind, logic [7:0] data,
                                        logic [1:0] status, logic last,
                                        logic [6:0] cnt);
        resp_t r;
        r.kind        = kind;
        r.data        = data;
        r.status      = status;
        r.last        = last;
        r.reply_count = cnt;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/rqle_cmd_if.sv -----
// request channel carrying one command item
`default_nettype none

interface rqle_cmd_if import rqle_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/rqle_resp_if.sv -----
// response channel carrying one result item
`default_nettype none

interface rqle_resp_if import rqle_pkg::*; ();
    logic  valid;
    logic  ready;
    resp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/rqle_core.sv -----
// query state, reply store and per-item result generation
`default_nettype none

module rqle_core import rqle_pkg::*; #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         protocol_sel,
    input  wire logic [15:0]  timeout_ticks,
    input  wire logic         accept,
    input  wire logic [5:0]   accept_index,
    input  wire logic         advance,
    input  wire cmd_t         item,
    output batch_t            batch,
    output core_status_t      status
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

    logic [7:0]    mem [STORE_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          busy_reg,   busy_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] expect_reg, expect_next;
    logic [7:0]    sum_reg,    sum_next;
    logic [15:0]   ticks_reg,  ticks_next;
    logic [7:0]    byte0_reg,  byte0_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = AW'(accept_index);
    assign status.busy = busy_reg;

    always_comb
    begin
        logic [8:0] count9;
        logic [8:0] inc9;
        logic [8:0] exp9;
        logic [8:0] len9;
        logic [7:0] check;
        logic [7:0] rd_val;
        count9      = 9'(count_reg);
        inc9        = count9 + 9'd1;
        exp9        = 9'(expect_reg);
        len9        = 9'd0;
        check       = ~sum_reg;
        rd_val      = 8'd0;
        busy_next   = busy_reg;
        count_next  = count_reg;
        expect_next = expect_reg;
        sum_next    = sum_reg;
        ticks_next  = ticks_reg;
        byte0_next  = byte0_reg;
        wr_en       = 1'b0;
        batch       = '0;
        case (item.op)
            OP_START:
            begin
                busy_next  = 1'b1;
                count_next = '0;
                sum_next   = 8'd0;
                ticks_next = 16'd0;
                if (protocol_sel)
                begin
                    batch.count    = S_FRAME_LEN;
                    batch.items[0] = make_resp(KIND_TX, S_HEAD, ST_OK, 1'b0, 7'd0);
                    batch.items[1] = make_resp(KIND_TX, item.register_id, ST_OK, 1'b0,
                                               7'd0);
                    batch.items[2] = make_resp(KIND_TX,
                                               ~(8'(S_HEAD + item.register_id)),
                                               ST_OK, 1'b1, 7'd0);
                    if (item.register_id == ID_SHORT)
                        len9 = LEN_SHORT;
                    else if (item.register_id == ID_TINY)
                        len9 = LEN_TINY;
                    else
                        len9 = LEN_S_OTHER;
                end
                else
                begin
                    batch.count    = I_FRAME_LEN;
                    batch.items[0] = make_resp(KIND_TX, I_HEAD, ST_OK, 1'b0, 7'd0);
                    batch.items[1] = make_resp(KIND_TX, I_CMD, ST_OK, 1'b0, 7'd0);
                    batch.items[2] = make_resp(KIND_TX, item.register_id, ST_OK, 1'b0,
                                               7'd0);
                    batch.items[3] = make_resp(KIND_TX,
                                               ~(8'(I_HEAD + I_CMD + item.register_id)),
                                               ST_OK, 1'b1, 7'd0);
                    len9 = LEN_I_START;
                end
                expect_next = CW'(len9);
            end
            OP_BYTE:
            begin
                if (busy_reg && count9 < DEPTH9)
                begin
                    wr_en      = 1'b1;
                    count_next = CW'(inc9);
                    sum_next   = sum_reg + item.rx_byte;
                    if (count_reg == '0)
                        byte0_next = item.rx_byte;
                    if (!protocol_sel && inc9 == LEN_I_POS)
                    begin
                        exp9 = {1'b0, item.rx_byte} + LEN_I_EXTRA;
                        if (exp9 > DEPTH9)
                            exp9 = DEPTH9;
                        expect_next = CW'(exp9);
                    end
                    if (inc9 == REJ_POS && byte0_reg == REJ_B0 && item.rx_byte == REJ_B1)
                    begin
                        busy_next      = 1'b0;
                        batch.count    = 3'd1;
                        batch.items[0] = make_resp(KIND_FINISH, 8'd0, ST_REJECT, 1'b0,
                                                   7'(inc9));
                    end
                    else if (inc9 >= exp9)
                    begin
                        busy_next      = 1'b0;
                        batch.count    = 3'd1;
                        batch.items[0] = make_resp(KIND_FINISH, check,
                                                   (check == item.rx_byte) ? ST_OK
                                                                           : ST_MISMATCH,
                                                   1'b0, 7'(inc9));
                    end
                end
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    if (ticks_reg != 16'hFFFF)
                        ticks_next = ticks_reg + 16'd1;
                    if (ticks_next >= timeout_ticks)
                    begin
                        busy_next      = 1'b0;
                        batch.count    = 3'd1;
                        batch.items[0] = make_resp(KIND_FINISH, 8'd0, ST_TIMEOUT, 1'b0,
                                                   7'(count_reg));
                    end
                end
            end
            OP_READ:
            begin
                if (9'(item.read_index) < count9)
                    rd_val = rd_data_reg;
                batch.count    = 3'd1;
                batch.items[0] = make_resp(KIND_READ, rd_val, ST_OK, 1'b0, 7'(count_reg));
            end
            default:
            begin
                batch = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            count_reg  <= '0;
            expect_reg <= '0;
            sum_reg    <= 8'd0;
            ticks_reg  <= 16'd0;
            byte0_reg  <= 8'd0;
        end
        else if (advance)
        begin
            busy_reg   <= busy_next;
            count_reg  <= count_next;
            expect_reg <= expect_next;
            sum_reg    <= sum_next;
            ticks_reg  <= ticks_next;
            byte0_reg  <= byte0_next;
        end
    end

    // reply store; a read taken at the same edge as a write to its entry sees the new byte
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
            mem[wr_addr] <= item.rx_byte;
        if (accept)
        begin
            if (advance && wr_en && wr_addr == rd_addr)
                rd_data_reg <= item.rx_byte;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/rqle_result_buf.sv -----
// result buffer holding up to one frame of results, drained one per handshake
`default_nettype none

module rqle_result_buf import rqle_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire batch_t batch,
    input  wire logic   pop,
    output resp_t       head,
    output logic        head_valid,
    output logic        free,
    output logic [2:0]  level
);

    resp_t [3:0] items_reg, items_next;
    logic [2:0]  level_reg, level_next;

    assign head       = items_reg[0];
    assign head_valid = (level_reg != 3'd0);
    assign free       = (level_reg == 3'd0) || (level_reg == 3'd1 && pop);
    assign level      = level_reg;

    always_comb
    begin
        items_next = items_reg;
        level_next = level_reg;
        if (pop)
        begin
            for (int i = 0; i < 3; i++)
                items_next[i] = items_reg[i + 1];
            level_next = level_reg - 3'd1;
        end
        if (load)
        begin
            items_next = batch.items;
            level_next = batch.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= 3'd0;
        else
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

`default_nettype wire

// ----- src/register_query_link_engine.sv -----
// top level of the register query link engine
//
// cmd takes one request per cycle while the result buffer is free: start query,
// received link byte, time tick or read of a stored reply byte. resp returns
// results: the 3 or 4 bytes of a query frame (last marks the final one), at most
// one finish result per query with its status and, for a full reply, its check
// byte, or one read result. A request is registered at the input and handled
// once the result buffer is free; its results are registered in the result
// buffer before they are offered. Byte, tick and read requests go through at one
// per cycle while the buffer is free. A start request occupies the result buffer
// until its 3 or 4 results are taken, so cmd.ready drops until the frame has drained.
// Reply bytes live in a store of STORE_DEPTH bytes with one write and one read
// port, read when the request is accepted, ahead of its handling.
// Configuration is written on cfg_we with cfg_index selecting the register.
// Reset brings protocol select 0, timeout 1000 ticks and no query running;
// the reply store is not cleared.
// While resp.ready is low the result buffer holds its items; cmd keeps taking
// requests until the input register and the buffer are both full.
`default_nettype none

module register_query_link_engine import rqle_pkg::*; #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    rqle_cmd_if.sink         cmd,
    rqle_resp_if.source      resp
);

    logic         protocol_reg;
    logic [15:0]  timeout_reg;
    cmd_t         cmd_reg;
    logic         cmd_valid_reg;
    logic         accept;
    logic         advance;
    logic         buf_free;
    logic         pop;
    logic [2:0]   buf_level;
    batch_t       batch;
    core_status_t core_st;

    assign advance   = cmd_valid_reg && buf_free;
    assign cmd.ready = !cmd_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;
    assign pop       = resp.valid && resp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROTOCOL: protocol_reg <= cfg_wdata[0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                default:      protocol_reg <= protocol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd.ready)
            cmd_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd.payload;
    end

    rqle_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .protocol_sel  (protocol_reg),
        .timeout_ticks (timeout_reg),
        .accept        (accept),
        .accept_index  (cmd.payload.read_index),
        .advance       (advance),
        .item          (cmd_reg),
        .batch         (batch),
        .status        (core_st)
    );

    rqle_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .batch      (batch),
        .pop        (pop),
        .head       (resp.payload),
        .head_valid (resp.valid),
        .free       (buf_free),
        .level      (buf_level)
    );

    // a query ends only through a finish result
    a_busy_ends_with_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(core_st.busy) |-> $past(advance) && $past(batch.count) == 3'd1
                                && $past(batch.items[0].kind) == KIND_FINISH
    ) else $error("query left busy without a finish result");

    // finish results come only from a running query
    a_finish_needs_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && batch.count != 3'd0 && batch.items[0].kind == KIND_FINISH
        |-> core_st.busy
    ) else $error("finish result produced while idle");

    // buffer never holds more than one frame
    a_buf_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        buf_level <= 3'd4
    ) else $error("result buffer overfilled");

endmodule

`default_nettype wire

// ----- tb/tb_register_query_link_engine.sv -----
// self-checking testbench for the register query link engine: directed table, then random queries
module tb_register_query_link_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import rqle_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int LONG_HOLD   = 64;

    typedef struct packed {
        logic        cfg_row;
        logic [1:0]  op;
        logic [7:0]  arg_id;
        logic [7:0]  arg_byte;
        logic [5:0]  arg_idx;
        logic        proto;
        logic [15:0] tmo;
        logic        typed;
        logic [1:0]  t_kind;
        logic [7:0]  t_data;
        logic [1:0]  t_status;
        logic        t_last;
        logic [6:0]  t_count;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    rqle_cmd_if  cmd ();
    rqle_resp_if resp ();

    register_query_link_engine #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .resp      (resp)
    );

    // engine state as the link sees it
    logic        lk_proto   = 1'b0;
    logic [15:0] lk_timeout = TIMEOUT_RESET;
    logic        lk_busy    = 1'b0;
    logic [7:0]  lk_store [STORE_DEPTH];
    logic [6:0]  lk_count   = '0;
    logic [8:0]  lk_len     = '0;
    logic [7:0]  lk_sum     = '0;
    logic [15:0] lk_ticks   = '0;

    resp_t       engine_out_q [$];
    logic [7:0]  reply_plan [$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_asks   = 0;
    int          hold_seen   = 0;
    int          rx_hold     = 0;
    bit          failed      = 1'b0;

    plan_row_t directed_plan [24] = '{
        '{0, OP_READ,  8'h00, 8'h00, 6'd0,  0, 16'd0,     1, KIND_READ,   8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'hA5, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_TICK,  8'h00, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_READ,  8'h00, 8'h00, 6'd63, 0, 16'd0,     1, KIND_READ,   8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'h00, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h15, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'hEA, 6'd0,  0, 16'd0,     1, KIND_FINISH, 8'h00, ST_REJECT,  0, 7'd2},
        '{0, OP_READ,  8'h00, 8'h00, 6'd1,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'hFF, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h01, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h02, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{1, OP_START, 8'h00, 8'h00, 6'd0,  0, 16'd1,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'h10, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_TICK,  8'h00, 8'h00, 6'd0,  0, 16'd0,     1, KIND_FINISH, 8'h00, ST_TIMEOUT, 0, 7'd0},
        '{1, OP_START, 8'h00, 8'h00, 6'd0,  1, 16'hFFFF,  0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'h56, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h10, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h20, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h30, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_BYTE,  8'h00, 8'h9F, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_READ,  8'h00, 8'h00, 6'd3,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'h50, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0},
        '{0, OP_START, 8'hAB, 8'h00, 6'd0,  0, 16'd0,     0, KIND_TX,     8'h00, ST_OK,      0, 7'd0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic resp_t link_res(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
                                       logic last);
        resp_t r;
        r.kind        = kind;
        r.data        = data;
        r.status      = status;
        r.last        = last;
        r.reply_count = lk_count;
        return r;
    endfunction

    task automatic link_engine_step(input cmd_t req);
        logic [7:0] chk;
        logic [8:0] len_next;
        case (req.op)
            OP_START:
            begin
                lk_busy  = 1'b1;
                lk_count = '0;
                lk_sum   = '0;
                lk_ticks = '0;
                if (lk_proto)
                begin
                    chk = ~(S_HEAD + req.register_id);
                    engine_out_q.push_back(link_res(KIND_TX, S_HEAD, ST_OK, 1'b0));
                    engine_out_q.push_back(link_res(KIND_TX, req.register_id, ST_OK, 1'b0));
                    engine_out_q.push_back(link_res(KIND_TX, chk, ST_OK, 1'b1));
                    lk_len = (req.register_id == ID_SHORT) ? LEN_SHORT :
                             (req.register_id == ID_TINY) ? LEN_TINY : LEN_S_OTHER;
                end
                else
                begin
                    chk = ~(I_HEAD + I_CMD + req.register_id);
                    engine_out_q.push_back(link_res(KIND_TX, I_HEAD, ST_OK, 1'b0));
                    engine_out_q.push_back(link_res(KIND_TX, I_CMD, ST_OK, 1'b0));
                    engine_out_q.push_back(link_res(KIND_TX, req.register_id, ST_OK, 1'b0));
                    engine_out_q.push_back(link_res(KIND_TX, chk, ST_OK, 1'b1));
                    lk_len = LEN_I_START;
                end
            end
            OP_BYTE:
            begin
                if (lk_busy && lk_count < STORE_DEPTH)
                begin
                    chk = ~lk_sum;
                    lk_store[lk_count[5:0]] = req.rx_byte;
                    lk_count++;
                    lk_sum = lk_sum + req.rx_byte;
                    if (!lk_proto && lk_count == LEN_I_POS)
                    begin
                        len_next = {1'b0, req.rx_byte} + LEN_I_EXTRA;
                        lk_len   = (len_next > STORE_DEPTH) ? 9'(STORE_DEPTH) : len_next;
                    end
                    if (lk_count == REJ_POS && lk_store[0] == REJ_B0 && lk_store[1] == REJ_B1)
                    begin
                        lk_busy = 1'b0;
                        engine_out_q.push_back(link_res(KIND_FINISH, 8'h00, ST_REJECT, 1'b0));
                    end
                    else if (lk_count >= lk_len)
                    begin
                        lk_busy = 1'b0;
                        engine_out_q.push_back(link_res(KIND_FINISH, chk,
                            (chk == req.rx_byte) ? ST_OK : ST_MISMATCH, 1'b0));
                    end
                end
            end
            OP_TICK:
            begin
                if (lk_busy)
                begin
                    if (lk_ticks != 16'hFFFF)
                        lk_ticks++;
                    if (lk_ticks >= lk_timeout)
                    begin
                        lk_busy = 1'b0;
                        engine_out_q.push_back(link_res(KIND_FINISH, 8'h00, ST_TIMEOUT, 1'b0));
                    end
                end
            end
            default:
            begin
                engine_out_q.push_back(link_res(KIND_READ,
                    (req.read_index < lk_count) ? lk_store[req.read_index] : 8'h00, ST_OK, 1'b0));
            end
        endcase
    endtask

    task automatic push_request(input cmd_t req, output bit counted);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.payload <= req;
        do @(posedge clk); while (!cmd.ready);
        counted = (req.op == OP_START || req.op == OP_READ || lk_busy);
        link_engine_step(req);
    endtask

    // close any open query, then let the engine go quiet
    task automatic drain_link();
        cmd_t req;
        bit   counted;
        while (lk_busy)
        begin
            req         = cmd_t'(24'($urandom));
            req.op      = OP_BYTE;
            push_request(req, counted);
        end
        reply_plan.delete();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (engine_out_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_link(input logic proto, input logic [15:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PROTOCOL;
        cfg_wdata <= {15'd0, proto};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge clk);
        cfg_we <= 1'b0;
        lk_proto   = proto;
        lk_timeout = tmo;
    endtask

    // reply bytes for the query just started, mostly well formed
    task automatic plan_reply(input logic [7:0] id);
        int         len;
        int         r;
        logic [7:0] b2;
        logic [7:0] sum;
        logic [7:0] b;
        reply_plan.delete();
        r   = $urandom_range(0, 99);
        b2  = '0;
        sum = '0;
        if (lk_proto)
            len = (id == ID_SHORT) ? 6 : (id == ID_TINY) ? 4 : 18;
        else if (r < 10)
        begin
            b2  = 8'($urandom_range(0, 1));
            len = 3;
        end
        else if (r < 20)
        begin
            b2  = 8'($urandom_range(62, 255));
            len = STORE_DEPTH;
        end
        else if (r < 35)
        begin
            len = $urandom_range(21, 63);
            b2  = 8'(len - 2);
        end
        else
        begin
            len = $urandom_range(4, 20);
            b2  = 8'(len - 2);
        end
        for (int k = 0; k < len - 1; k++)
        begin
            b = (!lk_proto && k == 2) ? b2 : 8'($urandom);
            reply_plan.push_back(b);
            sum = sum + b;
        end
        reply_plan.push_back((!lk_proto && len == 3) ? b2 : ~sum);
        r = $urandom_range(0, 99);
        if (r < 10)
            reply_plan[reply_plan.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
        else if (r < 18)
        begin
            reply_plan.delete();
            reply_plan.push_back(REJ_B0);
            reply_plan.push_back(REJ_B1);
        end
        else if (r < 30)
            repeat ($urandom_range(1, reply_plan.size() - 1)) void'(reply_plan.pop_back());
    endtask

    task automatic random_phase(input logic proto, input logic [15:0] tmo, input int target,
                                input int pct, input bit press_rx, input bit press_tx);
        int   done;
        int   r;
        bit   counted;
        bit   held;
        bit   paused;
        cmd_t req;
        drain_link();
        program_link(proto, tmo);
        tx_idle_pct = pct;
        rx_idle_pct = pct;
        held   = 1'b0;
        paused = 1'b0;
        done   = 0;
        while (done < target)
        begin
            if (press_rx && !held && done >= target / 3)
            begin
                held = 1'b1;
                hold_asks <= hold_asks + 1;
            end
            if (press_tx && !paused && done >= target / 2)
            begin
                paused = 1'b1;
                cmd.valid <= 1'b0;
                do @(posedge clk); while (engine_out_q.size() != 0);
            end
            if (!lk_busy)
                reply_plan.delete();
            r   = $urandom_range(0, 99);
            req = cmd_t'(24'($urandom));
            if (lk_busy && reply_plan.size() != 0)
            begin
                if (r < 74)
                begin
                    req.op      = OP_BYTE;
                    req.rx_byte = reply_plan.pop_front();
                end
                else if (r < 84)
                    req.op = OP_TICK;
                else if (r < 92)
                    req.op = OP_READ;
                else if (r < 96)
                    req.op = OP_BYTE;
                else
                    req.op = OP_START;
            end
            else if (lk_busy)
            begin
                if (r < 60)
                    req.op = OP_TICK;
                else if (r < 75)
                    req.op = OP_READ;
                else if (r < 85)
                    req.op = OP_BYTE;
                else
                    req.op = OP_START;
            end
            else
            begin
                if (r < 45)
                    req.op = OP_START;
                else if (r < 62)
                    req.op = OP_TICK;
                else if (r < 84)
                    req.op = OP_READ;
                else
                    req.op = OP_BYTE;
            end
            r = $urandom_range(0, 99);
            if (req.op == OP_START && lk_proto && r < 30)
                req.register_id = ID_SHORT;
            else if (req.op == OP_START && lk_proto && r < 60)
                req.register_id = ID_TINY;
            if (req.op == OP_READ && lk_count != 0 && r < 60)
                req.read_index = 6'($urandom_range(0, lk_count - 1));
            push_request(req, counted);
            if (req.op == OP_START)
                plan_reply(req.register_id);
            if (counted)
                done++;
        end
    endtask

    // result side: random stalls, one long hold-off on demand
    always @(posedge clk)
    begin
        if (!rst_n)
            resp.ready <= 1'b0;
        else if (hold_seen != hold_asks)
        begin
            hold_seen  <= hold_asks;
            rx_hold    <= LONG_HOLD - 1;
            resp.ready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold    <= rx_hold - 1;
            resp.ready <= 1'b0;
        end
        else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
        begin
            rx_hold    <= $urandom_range(0, 3);
            resp.ready <= 1'b0;
        end
        else
            resp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        resp_t want;
        if (rst_n && resp.valid && resp.ready)
        begin
            if (engine_out_q.size() == 0)
            begin
                $error("result with none pending: kind %0d data %02h status %0d",
                       resp.payload.kind, resp.payload.data, resp.payload.status);
                failed = 1'b1;
            end
            else
            begin
                want = engine_out_q.pop_front();
                if (resp.payload.kind != want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, resp.payload.kind);
                    failed = 1'b1;
                end
                if (resp.payload.data != want.data)
                begin
                    $error("data: expected %02h, got %02h", want.data, resp.payload.data);
                    failed = 1'b1;
                end
                if (resp.payload.status != want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, resp.payload.status);
                    failed = 1'b1;
                end
                if (resp.payload.last != want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, resp.payload.last);
                    failed = 1'b1;
                end
                if (resp.payload.reply_count != want.reply_count)
                begin
                    $error("reply_count: expected %0d, got %0d", want.reply_count,
                           resp.payload.reply_count);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("[register_query_link_engine] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t row;
        cmd_t      req;
        bit        counted;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_PROTOCOL;
        cfg_wdata   <= '0;
        cmd.valid   <= 1'b0;
        cmd.payload <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rx_idle_pct = 20;
        tx_idle_pct = 20;
        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.cfg_row)
            begin
                drain_link();
                program_link(row.proto, row.tmo);
            end
            else
            begin
                req.op          = row.op;
                req.register_id = row.arg_id;
                req.rx_byte     = row.arg_byte;
                req.read_index  = row.arg_idx;
                push_request(req, counted);
                if (row.typed)
                    engine_out_q[engine_out_q.size() - 1] =
                        '{row.t_kind, row.t_data, row.t_status, row.t_last, row.t_count};
            end
        end

        random_phase(1'b0, TIMEOUT_RESET, 26, 25, 1'b0, 1'b0);
        random_phase(1'b1, 16'd12,        26, 0,  1'b1, 1'b0);
        random_phase(1'b0, 16'd1,         26, 25, 1'b0, 1'b0);
        random_phase(1'b1, 16'hFFFF,      26, 25, 1'b0, 1'b1);
        random_phase(1'b0, 16'd6,         26, 0,  1'b0, 1'b0);
        // closing stretch runs with no stalls on either side
        random_phase(1'b1, 16'd300,       26, 0,  1'b0, 1'b0);
        drain_link();

        if (!failed)
            $display("[register_query_link_engine] OK");
        else
            $display("[register_query_link_engine] ERROR");
        $finish;
    end

endmodule
